// File: sv/mrt_pkg.sv
// shared types and constants of the trained manchester receiver
package mrt_pkg;

    localparam int FRAME_W       = 16;
    localparam int REST_W        = 24;
    localparam int NUM_INTERVALS = 6;
    localparam int CNT_W         = 3;

    // one result transaction as it leaves the frame receiver
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame_data;
        logic               sync_error;
    } result_t;

endpackage

// File: sv/manchester_receiver_trained_top.sv
// top level of the trained manchester receiver
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   line_level
//   output    out        out_valid / out_stall frame_data, sync_error
//   config    in         cfg_write             cfg_data (rest_ticks)
//
// one line sample per clock while in_stall is low: a sample is registered, then decoded
// by the period trainer and frame receiver once the output side has room; the result
// lands in the output register, or in the skid entry while that one is full; the output
// register plus one skid entry lets samples keep flowing while a result waits, in_stall
// rises only when both hold
// reset clears training, returns to waiting for a high level and zeroes rest_ticks
module manchester_receiver_trained_top #(
    parameter int MSG_BITS  = 16,
    parameter int TICK_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [mrt_pkg::REST_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         line_level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mrt_pkg::FRAME_W-1:0]  frame_data,
    output logic                         sync_error
);
    import mrt_pkg::*;

    logic                 s_valid_reg;
    logic                 s_level_reg;
    logic [REST_W-1:0]    rest_ticks_reg;
    logic                 room;
    logic                 advance;
    logic                 trained;
    logic [TICK_BITS-1:0] bit_period;
    result_t              result;

    // decode the registered sample only when a result has somewhere to go
    assign advance  = s_valid_reg && room;
    assign in_stall = s_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg    <= 1'b0;
            s_level_reg    <= 1'b0;
            rest_ticks_reg <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                s_valid_reg <= in_valid;
                s_level_reg <= line_level;
            end
            if (cfg_write)
                rest_ticks_reg <= cfg_data;
        end
    end

    // six-interval average sets the bit period once
    mrt_trainer #(
        .TICK_BITS (TICK_BITS)
    ) u_trainer (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .line_level (s_level_reg),
        .trained    (trained),
        .bit_period (bit_period)
    );

    // receive state machine sees the period as it stood before this sample
    mrt_frame_rx #(
        .MSG_BITS  (MSG_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_frame_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .line_level (s_level_reg),
        .trained    (trained),
        .bit_period (bit_period),
        .rest_ticks (rest_ticks_reg),
        .result     (result)
    );

    // output register and skid entry
    mrt_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .result     (result),
        .out_stall  (out_stall),
        .room       (room),
        .out_valid  (out_valid),
        .frame_data (frame_data),
        .sync_error (sync_error)
    );

endmodule

// File: sv/mrt_trainer.sv
// bit period estimator: times six line intervals and averages them
module mrt_trainer #(
    parameter int TICK_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 line_level,
    output logic                 trained,
    output logic [TICK_BITS-1:0] bit_period
);
    import mrt_pkg::*;

    // intervals are kept as quotient and remainder by six, so the average is a plain add
    localparam int               QW       = TICK_BITS - 2;
    localparam longint unsigned  TICK_MAX = (64'd1 << TICK_BITS) - 64'd1;
    localparam logic [QW-1:0]    MAX_Q    = QW'(TICK_MAX / NUM_INTERVALS);
    localparam logic [2:0]       MAX_R    = 3'(TICK_MAX % NUM_INTERVALS);
    localparam logic [2:0]       LAST_R   = 3'(NUM_INTERVALS - 1);
    localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(NUM_INTERVALS);

    logic                 prev_level_reg;
    logic                 first_seen_reg;
    logic [QW-1:0]        iq_reg;
    logic [2:0]           ir_reg;
    logic [CNT_W-1:0]     taken_reg;
    logic [TICK_BITS-1:0] sum_q_reg;
    logic [2:0]           sum_r_reg;
    logic [TICK_BITS-1:0] period_reg;
    logic                 trained_reg;

    logic                 saturated;
    logic [QW-1:0]        cnt_q;
    logic [2:0]           cnt_r;
    logic [3:0]           r_add;
    logic                 carry;
    logic [2:0]           sum_r_next;
    logic [TICK_BITS-1:0] sum_q_next;
    logic [CNT_W-1:0]     taken_next;
    logic                 take;

    // saturating interval count, one tick on
    always_comb
    begin
        saturated = (iq_reg == MAX_Q) && (ir_reg == MAX_R);
        if (saturated)
        begin
            cnt_q = iq_reg;
            cnt_r = ir_reg;
        end
        else if (ir_reg == LAST_R)
        begin
            cnt_q = iq_reg + QW'(1);
            cnt_r = '0;
        end
        else
        begin
            cnt_q = iq_reg;
            cnt_r = ir_reg + 3'd1;
        end
    end

    always_comb
    begin
        r_add      = {1'b0, sum_r_reg} + {1'b0, cnt_r};
        carry      = (r_add >= 4'(NUM_INTERVALS));
        sum_r_next = carry ? 3'(r_add - 4'(NUM_INTERVALS)) : r_add[2:0];
        sum_q_next = sum_q_reg + TICK_BITS'(cnt_q) + TICK_BITS'(carry);
        taken_next = taken_reg + CNT_W'(1);
        take       = first_seen_reg && (taken_reg < CNT_DONE) && !trained_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            first_seen_reg <= 1'b0;
            iq_reg         <= '0;
            ir_reg         <= '0;
            taken_reg      <= '0;
            sum_q_reg      <= '0;
            sum_r_reg      <= '0;
            period_reg     <= '0;
            trained_reg    <= 1'b0;
        end
        else if (advance)
        begin
            prev_level_reg <= line_level;
            if (line_level != prev_level_reg)
            begin
                if (take)
                begin
                    sum_q_reg <= sum_q_next;
                    sum_r_reg <= sum_r_next;
                    taken_reg <= taken_next;
                    if (taken_next == CNT_DONE)
                    begin
                        period_reg  <= sum_q_next;
                        trained_reg <= 1'b1;
                    end
                end
                first_seen_reg <= 1'b1;
                iq_reg         <= '0;
                ir_reg         <= '0;
            end
            else
            begin
                iq_reg <= cnt_q;
                ir_reg <= cnt_r;
            end
        end
    end

    assign trained    = trained_reg;
    assign bit_period = period_reg;

endmodule

// File: sv/mrt_frame_rx.sv
// frame receiver: start detection, half-cell timing and bit decisions
module mrt_frame_rx #(
    parameter int MSG_BITS  = 16,
    parameter int TICK_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        line_level,
    input  logic                        trained,
    input  logic [TICK_BITS-1:0]        bit_period,
    input  logic [mrt_pkg::REST_W-1:0]  rest_ticks,
    output mrt_pkg::result_t            result
);
    import mrt_pkg::*;

    localparam int WAIT_W = (TICK_BITS > REST_W) ? TICK_BITS : REST_W;
    localparam int BW     = $clog2(MSG_BITS + 1);
    localparam int EXT_W  = (MSG_BITS > FRAME_W) ? MSG_BITS : FRAME_W;

    typedef enum logic [5:0] {
        PH_WAIT_HIGH = 6'b000001,
        PH_WAIT_FALL = 6'b000010,
        PH_FIRST     = 6'b000100,
        PH_SECOND    = 6'b001000,
        PH_FINISH    = 6'b010000,
        PH_REST      = 6'b100000
    } rx_phase_t;

    rx_phase_t           phase_reg, phase_next, eff;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic                first_reg, first_next;
    logic [BW-1:0]       bits_reg, bits_next, bits_inc;
    logic [MSG_BITS-1:0] word_reg, word_next;
    logic [WAIT_W-1:0]   half;
    logic [EXT_W-1:0]    word_ext;
    logic                hold;

    assign half     = WAIT_W'(bit_period >> 1);
    assign word_ext = EXT_W'(word_reg);
    assign bits_inc = bits_reg + BW'(1);

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        first_next = first_reg;
        bits_next  = bits_reg;
        word_next  = word_reg;
        result     = '0;
        eff        = phase_reg;
        hold       = 1'b0;
        if (advance && trained)
        begin
            // rest countdown; its last tick falls through to the start search
            if (phase_reg == PH_REST)
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                    hold      = 1'b1;
                end
                else
                begin
                    eff = PH_WAIT_HIGH;
                end
            end
            if (!hold)
            begin
                phase_next = eff;
                case (eff)
                    PH_WAIT_HIGH:
                    begin
                        if (line_level)
                            phase_next = PH_WAIT_FALL;
                    end
                    PH_WAIT_FALL:
                    begin
                        if (!line_level)
                        begin
                            wait_next  = half;
                            bits_next  = '0;
                            word_next  = '0;
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_FIRST:
                    begin
                        if (wait_reg != '0)
                            wait_next = wait_reg - WAIT_W'(1);
                        else
                        begin
                            first_next = line_level;
                            wait_next  = half;
                            phase_next = PH_SECOND;
                        end
                    end
                    PH_SECOND:
                    begin
                        if (wait_reg != '0)
                            wait_next = wait_reg - WAIT_W'(1);
                        else if (first_reg == line_level)
                        begin
                            // no mid-cell transition
                            result.valid      = 1'b1;
                            result.sync_error = 1'b1;
                            word_next         = '0;
                            bits_next         = '0;
                            phase_next        = PH_WAIT_HIGH;
                        end
                        else
                        begin
                            word_next  = MSG_BITS'({word_reg, line_level});
                            bits_next  = bits_inc;
                            wait_next  = half;
                            phase_next = (bits_inc >= BW'(MSG_BITS)) ? PH_FINISH : PH_FIRST;
                        end
                    end
                    PH_FINISH:
                    begin
                        if (wait_reg != '0)
                            wait_next = wait_reg - WAIT_W'(1);
                        else
                        begin
                            result.valid      = 1'b1;
                            result.frame_data = word_ext[FRAME_W-1:0];
                            bits_next         = '0;
                            wait_next         = WAIT_W'(rest_ticks);
                            phase_next        = PH_REST;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT_HIGH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_HIGH;
            wait_reg  <= '0;
            first_reg <= 1'b0;
            bits_reg  <= '0;
            word_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            first_reg <= first_next;
            bits_reg  <= bits_next;
            word_reg  <= word_next;
        end
    end

endmodule

// File: sv/mrt_out_buf.sv
// result register with one skid entry on the output channel
module mrt_out_buf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mrt_pkg::result_t             result,
    input  logic                         out_stall,
    output logic                         room,
    output logic                         out_valid,
    output logic [mrt_pkg::FRAME_W-1:0]  frame_data,
    output logic                         sync_error
);
    import mrt_pkg::*;

    result_t out_reg;
    result_t skid_reg;
    logic    taken;

    assign taken = out_reg.valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (!out_reg.valid || taken)
        begin
            if (skid_reg.valid)
            begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
            else
            begin
                out_reg <= result;
            end
        end
        else if (result.valid)
        begin
            skid_reg <= result;
        end
    end

    assign room       = !skid_reg.valid;
    assign out_valid  = out_reg.valid;
    assign frame_data = out_reg.frame_data;
    assign sync_error = out_reg.sync_error;

endmodule
